>>> hw/rtl/time_binned_accumulation_queue_defines.svh
// ----------------------------------------------------------------------------
// Time-binned accumulation queue - assertion macros
// Concurrent assertion helpers clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TIME_BINNED_ACCUMULATION_QUEUE_DEFINES_SVH
`define TIME_BINNED_ACCUMULATION_QUEUE_DEFINES_SVH

// same-cycle implication
`define TBAQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TBAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tbaq_pkg.sv
// ----------------------------------------------------------------------------
// tbaq_pkg
// Shared constants, types and helpers of the time-binned accumulation queue.
// ----------------------------------------------------------------------------
package tbaq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int BATCH_W     = 21;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = DATA_W + $clog2(QUEUE_DEPTH + 2);
   localparam int STEP_W      = $clog2(DATA_W);
   localparam int PROD_W      = 2 * DATA_W;
   localparam int FRAC_W      = 16;

   localparam logic [DATA_W-1:0] SCALE_ONE = DATA_W'(65536);

   typedef enum logic [1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_COLLECT = 2'd1,
      FUNC_SCALE   = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_PUSH,
      ST_OPEN,
      ST_DRAIN,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic push_upd;
      logic open_upd;
      logic pop;
      logic mul;
      logic finish;
   } cmd_type;

   typedef struct packed {
      func_type          func;
      logic              drain_hit;
      logic              out_free;
      logic [CNT_W-1:0]  q_count;
   } status_type;

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DATA_W] ? '1 : s[DATA_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] i);
      return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + PTR_W'(1);
   endfunction

endpackage

>>> hw/rtl/tbaq_ctrl.sv
// ----------------------------------------------------------------------------
// tbaq_ctrl
// Sequencer: accepts a request, runs what its op needs of remainder steps,
// bin update or queue drain and multiply, then fills the output register.
// ----------------------------------------------------------------------------
module tbaq_ctrl
   import tbaq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            step_in = '0;
            case (sts.func)
               FUNC_PUSH, FUNC_COLLECT: state_in = ST_DIV;
               FUNC_SCALE:              state_in = ST_MUL;
               default:                 state_in = ST_FIN;
            endcase
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DATA_W - 1)) begin
               state_in = (sts.func == FUNC_PUSH) ? ST_PUSH : ST_OPEN;
            end
         end
         ST_PUSH: state_in = ST_FIN;
         ST_OPEN: state_in = ST_DRAIN;
         ST_DRAIN: begin
            if (!sts.drain_hit) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_FIN;
         ST_FIN: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_PUSH:  cmd.push_upd = 1'b1;
         ST_OPEN:  cmd.open_upd = 1'b1;
         ST_DRAIN: cmd.pop      = sts.drain_hit;
         ST_MUL:   cmd.mul      = 1'b1;
         ST_FIN:   cmd.finish   = sts.out_free;
         default: ;
      endcase
   end

endmodule

>>> hw/rtl/tbaq_dp.sv
// ----------------------------------------------------------------------------
// tbaq_dp
// Datapath: request registers, bit-serial remainder, open bin, bin queue
// memory, drain accumulator, scale multiplier and output register.
// ----------------------------------------------------------------------------
module tbaq_dp
   import tbaq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          sts,
   input  logic                csr_we,
   input  logic [BATCH_W-1:0]  csr_wdata,
   input  func_type            in_func,
   input  logic [DATA_W-1:0]   in_time,
   input  logic [DATA_W-1:0]   in_prob,
   input  logic [DATA_W-1:0]   in_factor,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [DATA_W-1:0]   out_collected,
   output logic                out_dropped,
   output logic [DATA_W-1:0]   out_pending
);

   logic [BATCH_W-1:0]  batch_ff;
   func_type            func_ff;
   logic [DATA_W-1:0]   time_ff, prob_ff, factor_ff, dvd_ff;
   logic [BATCH_W-1:0]  rem_ff;
   logic [PTR_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DATA_W-1:0]   open_start_ff, open_start_in;
   logic [DATA_W-1:0]   open_mass_ff, open_mass_in;
   logic [DATA_W-1:0]   total_ff, total_in;
   logic [DATA_W-1:0]   scale_ff, scale_in;
   logic                dropped_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                out_valid_ff;
   logic [DATA_W-1:0]   col_out_ff, pend_out_ff;
   logic                drop_out_ff;

   logic [DATA_W-1:0]   mem_start [QUEUE_DEPTH];
   logic [DATA_W-1:0]   mem_mass  [QUEUE_DEPTH];
   logic [DATA_W-1:0]   rd_start_ff, rd_mass_ff;
   logic                mem_we;

   logic [BATCH_W-1:0]  divisor;
   logic [BATCH_W:0]    rem_shift;
   logic                rem_ge;
   logic [DATA_W-1:0]   bin;
   logic                bin_later;
   logic                q_full;
   logic [DATA_W-1:0]   mul_a, mul_b;
   logic [DATA_W-1:0]   sat_prod;

   assign divisor   = (batch_ff == '0) ? BATCH_W'(1) : batch_ff;
   assign rem_shift = {rem_ff, dvd_ff[DATA_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, divisor};
   assign bin       = time_ff - {{(DATA_W-BATCH_W){1'b0}}, rem_ff};
   assign bin_later = bin > open_start_ff;
   assign q_full    = count_ff >= CNT_W'(QUEUE_DEPTH);
   assign mem_we    = cmd.push_upd && bin_later && !q_full;

   assign mul_a    = (func_ff == FUNC_COLLECT)
                   ? ((|sum_ff[SUM_W-1:DATA_W]) ? '1 : sum_ff[DATA_W-1:0])
                   : factor_ff;
   assign mul_b    = scale_ff;
   assign sat_prod = (|prod_ff[PROD_W-1:DATA_W+FRAC_W]) ? '1
                   : prod_ff[DATA_W+FRAC_W-1:FRAC_W];

   // queue pointers, open bin, totals
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      open_start_in = open_start_ff;
      open_mass_in  = open_mass_ff;
      total_in      = total_ff;
      scale_in      = scale_ff;
      if (cmd.push_upd) begin
         if (bin_later) begin
            open_start_in = bin;
            open_mass_in  = prob_ff;
            if (!q_full) begin
               tail_in  = next_ptr(tail_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            open_mass_in = sat_add(open_mass_ff, prob_ff);
         end
         total_in = sat_add(total_ff, prob_ff);
      end
      if (cmd.open_upd && bin_later) begin
         open_start_in = bin;
         open_mass_in  = '0;
      end
      if (cmd.pop) begin
         head_in  = next_ptr(head_ff);
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.mul && func_ff == FUNC_COLLECT) begin
         total_in = (sum_ff >= {{(SUM_W-DATA_W){1'b0}}, total_ff}) ? '0
                  : DATA_W'({{(SUM_W-DATA_W){1'b0}}, total_ff} - sum_ff);
      end
      if (cmd.finish && func_ff == FUNC_SCALE) scale_in = sat_prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff      <= BATCH_W'(1);
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         open_start_ff <= '0;
         open_mass_ff  <= '0;
         total_ff      <= '0;
         scale_ff      <= SCALE_ONE;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) batch_ff <= csr_wdata;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         open_start_ff <= open_start_in;
         open_mass_ff  <= open_mass_in;
         total_ff      <= total_in;
         scale_ff      <= scale_in;
         if (cmd.finish) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= in_func;
         time_ff    <= in_time;
         prob_ff    <= in_prob;
         factor_ff  <= in_factor;
         dvd_ff     <= in_time;
         rem_ff     <= '0;
         dropped_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DATA_W-2:0], 1'b0};
         rem_ff <= rem_ge ? BATCH_W'(rem_shift - {1'b0, divisor})
                          : rem_shift[BATCH_W-1:0];
      end
      if (cmd.push_upd && bin_later && q_full) dropped_ff <= 1'b1;
      if (cmd.open_upd) begin
         sum_ff <= bin_later ? {{(SUM_W-DATA_W){1'b0}}, open_mass_ff} : '0;
      end
      if (cmd.pop) sum_ff <= sum_ff + {{(SUM_W-DATA_W){1'b0}}, rd_mass_ff};
      if (cmd.mul) prod_ff <= mul_a * mul_b;
      if (cmd.finish) begin
         col_out_ff  <= (func_ff == FUNC_COLLECT) ? sat_prod : '0;
         drop_out_ff <= dropped_ff;
         pend_out_ff <= total_ff;
      end
   end

   // bin queue memory, read port follows the next head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_start[tail_ff] <= open_start_ff;
         mem_mass[tail_ff]  <= open_mass_ff;
      end
      rd_start_ff <= mem_start[head_in];
      rd_mass_ff  <= mem_mass[head_in];
   end

   assign sts.func      = func_ff;
   assign sts.drain_hit = (count_ff != '0) && (rd_start_ff <= time_ff);
   assign sts.out_free  = !out_valid_ff || out_ready;
   assign sts.q_count   = count_ff;

   assign out_valid     = out_valid_ff;
   assign out_collected = col_out_ff;
   assign out_dropped   = drop_out_ff;
   assign out_pending   = pend_out_ff;

endmodule

>>> hw/rtl/time_binned_accumulation_queue.sv
// Time-binned accumulation queue. One request is worked at a time. The bin
// start comes from a one-bit-per-cycle remainder over the 32-bit time; a
// collect then drains the queued bins starting at or before that time. A
// scale only multiplies and an unused op only finishes. The next request is
// taken while the previous result still waits in the output register. The bin
// queue has no reset pass and is usable right after reset.
// ----------------------------------------------------------------------------
// time_binned_accumulation_queue
// Top level: stream request/response channels, bin width register, sequencer
// and datapath.
// ----------------------------------------------------------------------------
`include "time_binned_accumulation_queue_defines.svh"

module time_binned_accumulation_queue
   import tbaq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [BATCH_W-1:0]  csr_wdata,    // batch_size
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [95:0]         req_tdata,    // time_req, prob, scale_factor
   input  logic [1:0]          req_tuser,    // func
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,    // collected, pending_total
   output logic                rsp_tuser     // dropped
);

   cmd_type     cmd;
   status_type  sts;
   logic [DATA_W-1:0] collected, pending;

   tbaq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tbaq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .in_func       (func_type'(req_tuser)),
      .in_time       (req_tdata[31:0]),
      .in_prob       (req_tdata[63:32]),
      .in_factor     (req_tdata[95:64]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_collected (collected),
      .out_dropped   (rsp_tuser),
      .out_pending   (pending)
   );

   assign rsp_tdata = {pending, collected};

   `TBAQ_ASSERT_IMPLY(a_count_bound, 1'b1, sts.q_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `TBAQ_ASSERT_IMPLY(a_pop_nonempty, cmd.pop, sts.q_count != '0, "pop from empty queue")
   `TBAQ_ASSERT_IMPLY(a_drop_no_collect, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == '0, "drop with mass")
   `TBAQ_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")

endmodule
